// ===== rtl/cobs_pkg.sv =====
// Package for the COBS frame decoder: field widths, status codes, register
// addresses and the result entry type shared by the interfaces, the decoder
// and its checker. No dependencies.
package cobs_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Frame status codes reported on a frame end result.
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO     = 2'd1;
   localparam status_type ST_TRUNC    = 2'd2;
   localparam status_type ST_OVERFLOW = 2'd3;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Code byte that opens a full group with no implied zero after it.
   localparam byte_type CODE_MAX = 8'hFF;

   // Register map.
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_OUT_LEN = 3'd0;
   localparam len_type MAX_OUT_LEN_RESET = 16'hFFFF;

   // Everything one encoded byte produces: an optional decoded byte and an
   // optional frame end report.
   typedef struct packed {
      logic       has_data;
      byte_type   data;
      logic       has_report;
      status_type status;
      len_type    length;
   } entry_type;

endpackage

// ===== rtl/cobs_if.sv =====
// Handshake interfaces for the COBS decoder's encoded byte input and its
// result output. Depends on cobs_pkg.
interface cobs_req_if;
   logic               valid;
   logic               ready;
   cobs_pkg::byte_type in_byte;
   logic               end_of_frame;

   modport source (output valid, output in_byte, output end_of_frame, input ready);
   modport sink   (input valid, input in_byte, input end_of_frame, output ready);
endinterface

interface cobs_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   cobs_pkg::byte_type   out_byte;
   cobs_pkg::status_type status;
   cobs_pkg::len_type    frame_length;
   logic                 last;

   modport source (output valid, output kind, output out_byte, output status,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input status,
                   input frame_length, input last, output ready);
endinterface

// ===== rtl/cobs_frame_decoder_unit.sv =====
// An accepted byte is held in the input register, decoded as it leaves it and written into
// the result queue, from whose head its first result is offered on rsp.
// Throughput: one encoded byte per cycle while the result queue has space. A byte
// with a decoded byte and a frame end report offers both in turn on the one result port.
// Reset (synchronous, active high) empties the pipeline, clears the frame state and sets
// max_out_len to 65535.
module cobs_frame_decoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   cobs_req_if.sink                         req,
   cobs_rsp_if.source                       rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cobs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cobs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cobs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import cobs_pkg::*;

   // Configuration.
   len_type    max_len_ff, max_len_in;
   logic       csr_write;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       in_eof_ff;
   logic       req_xfer;

   // Frame state.
   byte_type   run_ff, run_in, run_n;
   logic       zp_ff, zp_in, zp_n;
   len_type    count_ff, count_in, count_n;
   status_type err_ff, err_in, err_n;
   status_type final_st;
   logic       room;
   logic       emit_req;
   logic       emit;
   byte_type   emit_val;
   logic       advance;
   logic       push;
   entry_type  entry_in;

   // Result queue: two entries, each holding every result of one input byte.
   entry_type  queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       phase_ff, phase_in;
   entry_type  head;
   logic       show_data;
   logic       rsp_valid;
   logic       rsp_last;
   logic       rsp_xfer;
   logic       pop;

   // ---------------------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is tied high.
   // ---------------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ADDR_MAX_OUT_LEN);
   assign max_len_in = csr_write ? csr_pwdata[LEN_W-1:0] : max_len_ff;
   assign csr_prdata = (csr_paddr == ADDR_MAX_OUT_LEN) ? CSR_DATA_W'(max_len_ff) : '0;

   // ---------------------------------------------------------------------------------
   // Input register. It refills in the same cycle that its byte moves on, so a
   // transfer can happen every cycle while the result queue has space.
   // ---------------------------------------------------------------------------------
   assign advance   = in_valid_ff && ((fill_ff != 2'd2) || pop);
   assign req.ready = !in_valid_ff || advance;
   assign req_xfer  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------
   // Decode step. A code byte may first release the zero implied by the previous
   // short group; a data byte is passed on. Every emitted byte is checked against
   // the length limit, and the first error of a frame freezes the state until the
   // end of frame flag, where a report is produced and the state returns to reset.
   // ---------------------------------------------------------------------------------
   assign room = count_ff < max_len_ff;

   always_comb begin
      emit_req = 1'b0;
      emit_val = '0;
      err_n    = err_ff;
      run_n    = run_ff;
      zp_n     = zp_ff;
      if (err_ff == ST_OK) begin
         if (run_ff == '0) begin
            // Code byte position.
            if (zp_ff) begin
               emit_req = 1'b1;
               if (!room) begin
                  err_n = ST_OVERFLOW;
               end
            end
            if (err_n == ST_OK) begin
               if (in_byte_ff == '0) begin
                  err_n = ST_ZERO;
               end else begin
                  run_n = in_byte_ff - 8'd1;
                  zp_n  = (in_byte_ff != CODE_MAX);
               end
            end
         end else if (in_byte_ff == '0) begin
            err_n = ST_ZERO;
         end else begin
            emit_req = 1'b1;
            emit_val = in_byte_ff;
            if (!room) begin
               err_n = ST_OVERFLOW;
            end else begin
               run_n = run_ff - 8'd1;
            end
         end
      end
      emit     = emit_req && room;
      count_n  = emit ? (count_ff + 16'd1) : count_ff;
      // A frame that ends inside a group is truncated unless it already failed.
      final_st = ((err_n == ST_OK) && (run_n != '0)) ? ST_TRUNC : err_n;

      entry_in.has_data   = emit;
      entry_in.data       = emit_val;
      entry_in.has_report = in_eof_ff;
      entry_in.status     = final_st;
      entry_in.length     = (final_st == ST_OK) ? count_n : '0;
   end

   assign push = advance && (emit || in_eof_ff);

   // Next frame state: the end of frame flag returns everything to reset.
   always_comb begin
      run_in   = run_ff;
      zp_in    = zp_ff;
      count_in = count_ff;
      err_in   = err_ff;
      if (advance) begin
         if (in_eof_ff) begin
            run_in   = '0;
            zp_in    = 1'b0;
            count_in = '0;
            err_in   = ST_OK;
         end else begin
            run_in   = run_n;
            zp_in    = zp_n;
            count_in = count_n;
            err_in   = err_n;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result queue and output. The head entry shows its decoded byte first, then its
   // report; the entry leaves the queue with the transfer that carries last.
   // ---------------------------------------------------------------------------------
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (fill_ff != 2'd0);
   assign show_data = head.has_data && !phase_ff;
   assign rsp_last  = !show_data || !head.has_report;
   assign rsp_xfer  = rsp_valid && rsp.ready;
   assign pop       = rsp_xfer && rsp_last;

   assign rsp.valid        = rsp_valid;
   assign rsp.kind         = show_data ? KIND_DATA : KIND_REPORT;
   assign rsp.out_byte     = show_data ? head.data : '0;
   assign rsp.status       = show_data ? ST_OK : head.status;
   assign rsp.frame_length = show_data ? '0 : head.length;
   assign rsp.last         = rsp_last;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
      phase_in  = rsp_xfer ? !rsp_last : phase_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= MAX_OUT_LEN_RESET;
         in_valid_ff <= 1'b0;
         run_ff      <= '0;
         zp_ff       <= 1'b0;
         count_ff    <= '0;
         err_ff      <= ST_OK;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         fill_ff     <= '0;
         phase_ff    <= 1'b0;
      end else begin
         max_len_ff  <= max_len_in;
         in_valid_ff <= in_valid_in;
         run_ff      <= run_in;
         zp_ff       <= zp_in;
         count_ff    <= count_in;
         err_ff      <= err_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
         phase_ff    <= phase_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req.in_byte;
         in_eof_ff  <= req.end_of_frame;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== rtl/cobs_checker.sv =====
// Port-level checks for the COBS frame decoder and the bind that attaches them
// to cobs_frame_decoder_unit. Depends on cobs_pkg.
module cobs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_kind,
   input cobs_pkg::byte_type        rsp_out_byte,
   input cobs_pkg::status_type      rsp_status,
   input cobs_pkg::len_type         rsp_frame_length,
   input logic                      rsp_last
);
   import cobs_pkg::*;

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_frame_length) && $stable(rsp_last))
      else $error("result changed while stalled");

   // A frame end report always closes the results of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REPORT) |-> rsp_last)
      else $error("report without last");

   // A failed frame reports no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REPORT) && (rsp_status != ST_OK)
         |-> (rsp_frame_length == '0) && (rsp_out_byte == '0))
      else $error("failed frame report carries a length or byte");

   // A decoded byte carries neither status nor length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DATA) |-> (rsp_status == ST_OK)
         && (rsp_frame_length == '0))
      else $error("data result carries report fields");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind cobs_frame_decoder_unit cobs_checker u_cobs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_kind         (rsp.kind),
   .rsp_out_byte     (rsp.out_byte),
   .rsp_status       (rsp.status),
   .rsp_frame_length (rsp.frame_length),
   .rsp_last         (rsp.last)
);
